// ===== src/assert_macros.svh =====
// Assertion helpers for the field weakening block checkers.
// Every assertion is clocked on the rising edge and idle while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic check with a fixed message.
`define FWC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fwc assertion failed");

// Check with a caller supplied message.
`define FWC_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// ===== src/fwc_pkg.sv =====
// ----------------------------------------------------------------------------
// fwc_pkg
// Shared widths, constants and types of the field weakening current unit.
// ----------------------------------------------------------------------------
package fwc_pkg;

    localparam int StartW   = 31;       // start speed, unsigned Q15.16
    localparam int MaxW     = 28;       // weakening limit in uA
    localparam int SpeedW   = 32;       // signed Q16.16 speed
    localparam int DtW      = 17;       // step time in us
    localparam int OutW     = 29;       // signed current reference
    localparam int ProdW    = MaxW + StartW;
    localparam int DivSteps = MaxW;     // quotient is below the limit
    localparam int CntW     = $clog2(DivSteps);
    localparam int AddrW    = 3;
    localparam int DataW    = 32;

    localparam logic [DtW-1:0] StepMaxUs = DtW'(100000);

    // register index, taken from paddr[2]
    localparam logic RegStartSpeed = 1'b0;
    localparam logic RegMaxWeak    = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [StartW-1:0] start_speed;
        logic [MaxW-1:0]   max_weak;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic mul;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_status;

endpackage

// ===== src/fwc_if.sv =====
// ----------------------------------------------------------------------------
// fwc_if
// Valid/ready channels of the field weakening current unit.
// ----------------------------------------------------------------------------
interface fwc_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic signed [fwc_pkg::SpeedW-1:0]   speed;
    logic                                volt_sat;
    logic        [fwc_pkg::DtW-1:0]      step_time_us;

    modport source (output valid, op, speed, volt_sat, step_time_us,
                    input ready);
    modport sink   (input valid, op, speed, volt_sat, step_time_us,
                    output ready);
endinterface

interface fwc_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fwc_pkg::OutW-1:0]   d_current_ua;
    logic                              step_applied;

    modport source (output valid, d_current_ua, step_applied, input ready);
    modport sink   (input valid, d_current_ua, step_applied, output ready);
endinterface

// ===== src/fwc_regs.sv =====
// ----------------------------------------------------------------------------
// fwc_regs
// APB configuration registers: start speed and weakening current limit.
// ----------------------------------------------------------------------------
module fwc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fwc_pkg::AddrW-1:0]   paddr,
    input  logic [fwc_pkg::DataW-1:0]   pwdata,
    output logic [fwc_pkg::DataW-1:0]   prdata,
    output logic                        pready,
    output fwc_pkg::t_cfg               o_cfg
);

    fwc_pkg::t_cfg r_cfg;
    logic          wr_en;

    assign wr_en = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            unique case (paddr[2])
                fwc_pkg::RegStartSpeed: r_cfg.start_speed <= pwdata[fwc_pkg::StartW-1:0];
                fwc_pkg::RegMaxWeak:    r_cfg.max_weak    <= pwdata[fwc_pkg::MaxW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fwc_pkg::RegStartSpeed: prdata = fwc_pkg::DataW'(r_cfg.start_speed);
            fwc_pkg::RegMaxWeak:    prdata = fwc_pkg::DataW'(r_cfg.max_weak);
            default:                prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

endmodule

// ===== src/fwc_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwc_ctrl
// Sequencer: capture, multiply, restoring divide, finish and output handoff.
// ----------------------------------------------------------------------------
module fwc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  fwc_pkg::t_status  i_status,
    output fwc_pkg::t_cmd     o_cmd
);

    fwc_pkg::t_state            r_state, n_state;
    logic [fwc_pkg::CntW-1:0]   r_cnt, n_cnt;
    logic                       r_out_valid, n_out_valid;
    logic                       div_last;
    logic                       slot_free;

    assign div_last  = (r_cnt == fwc_pkg::CntW'(fwc_pkg::DivSteps - 1));
    assign slot_free = !r_out_valid || i_out_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fwc_pkg::S_IDLE: if (i_in_valid) n_state = fwc_pkg::S_MUL;
            fwc_pkg::S_MUL:  n_state = i_status.need_div ? fwc_pkg::S_DIV : fwc_pkg::S_FIN;
            fwc_pkg::S_DIV:  if (div_last) n_state = fwc_pkg::S_FIN;
            fwc_pkg::S_FIN:  if (slot_free) n_state = fwc_pkg::S_IDLE;
            default:         n_state = fwc_pkg::S_IDLE;
        endcase
    end

    // outputs and counter
    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            fwc_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            fwc_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt     = '0;
            end
            fwc_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
            end
            fwc_pkg::S_FIN: begin
                o_cmd.finish = slot_free;
                if (slot_free) n_out_valid = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwc_pkg::S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== src/fwc_dp.sv =====
// ----------------------------------------------------------------------------
// fwc_dp
// Datapath: speed magnitude, limit x excess product, shift-subtract divider,
// integrator update, clamp and minimum, output register.
// ----------------------------------------------------------------------------
module fwc_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fwc_pkg::t_cfg                      i_cfg,
    input  fwc_pkg::t_cmd                      i_cmd,
    output fwc_pkg::t_status                   o_status,
    input  logic                               i_op,
    input  logic signed [fwc_pkg::SpeedW-1:0]  i_speed,
    input  logic                               i_volt_sat,
    input  logic        [fwc_pkg::DtW-1:0]     i_step_time_us,
    output logic signed [fwc_pkg::OutW-1:0]    o_d_current_ua,
    output logic                               o_step_applied
);

    localparam int SW = fwc_pkg::SpeedW;
    localparam int QW = fwc_pkg::MaxW;
    localparam int RW = fwc_pkg::StartW;

    logic                                r_op;
    logic                                r_sat;
    logic        [fwc_pkg::DtW-1:0]      r_dt;
    logic        [SW-1:0]                r_mag;
    logic        [RW-1:0]                r_rem;
    logic        [QW-1:0]                r_quo;
    logic signed [fwc_pkg::OutW-1:0]     r_integ;
    logic signed [fwc_pkg::OutW-1:0]     r_d_out;
    logic                                r_applied;

    logic [SW-1:0]             start_ext;
    logic [SW-1:0]             excess;
    logic                      mag_gt;
    logic                      exc_ge;
    logic                      dt_ok;
    logic                      disabled;
    logic [fwc_pkg::ProdW-1:0] prod;
    logic [SW-1:0]             trial;
    logic [SW-1:0]             diff;
    logic                      trial_ge;

    logic        [23:0]        dec;
    logic        [20:0]        rise;
    logic signed [31:0]        base;
    logic signed [31:0]        v_step;
    logic signed [31:0]        v_clamp;
    logic signed [31:0]        lo;
    logic signed [31:0]        lin;
    logic signed [31:0]        res;

    assign start_ext = SW'(i_cfg.start_speed);
    assign excess    = r_mag - start_ext;
    assign mag_gt    = r_mag > start_ext;
    assign exc_ge    = excess >= start_ext;
    assign dt_ok     = (r_dt != '0) && (r_dt <= fwc_pkg::StepMaxUs);
    assign disabled  = r_op || (i_cfg.max_weak == '0);

    assign o_status.need_div = !disabled && dt_ok && (i_cfg.start_speed != '0)
                               && mag_gt && !exc_ge;

    // excess is below start speed whenever the product is used
    assign prod = fwc_pkg::ProdW'(i_cfg.max_weak) * fwc_pkg::ProdW'(excess[RW-1:0]);

    // one quotient bit per step
    assign trial    = {r_rem, r_quo[QW-1]};
    assign trial_ge = trial >= start_ext;
    assign diff     = trial - start_ext;

    // integrator: -100 uA/us when saturated, +10 uA/us while negative
    assign dec  = 24'({r_dt, 6'b0}) + 24'({r_dt, 5'b0}) + 24'({r_dt, 2'b0});
    assign rise = 21'({r_dt, 3'b0}) + 21'({r_dt, 1'b0});
    assign base = 32'(r_integ);
    assign lo   = -$signed({4'b0, i_cfg.max_weak});

    always_comb begin
        if (r_sat) begin
            v_step = base - $signed({8'b0, dec});
        end else if (base < 0) begin
            v_step = base + $signed({11'b0, rise});
        end else begin
            v_step = base;
        end
        if (v_step < lo) begin
            v_clamp = lo;
        end else if (v_step > 0) begin
            v_clamp = '0;
        end else begin
            v_clamp = v_step;
        end
    end

    always_comb begin
        if ((i_cfg.start_speed == '0) || !mag_gt) begin
            lin = '0;
        end else if (exc_ge) begin
            lin = lo;
        end else begin
            lin = -$signed({4'b0, r_quo});
        end
        res = (lin < v_clamp) ? lin : v_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_sat <= i_volt_sat;
            r_dt  <= i_step_time_us;
            r_mag <= i_speed[SW-1] ? (SW'(0) - i_speed) : i_speed;
        end
        if (i_cmd.mul) begin
            r_rem <= prod[fwc_pkg::ProdW-1:QW];
            r_quo <= prod[QW-1:0];
        end else if (i_cmd.div_step) begin
            r_rem <= trial_ge ? diff[RW-1:0] : trial[RW-1:0];
            r_quo <= {r_quo[QW-2:0], trial_ge};
        end
        if (i_cmd.finish) begin
            if (disabled || !dt_ok) begin
                r_d_out   <= '0;
                r_applied <= 1'b0;
            end else begin
                r_d_out   <= res[fwc_pkg::OutW-1:0];
                r_applied <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
        end else if (i_cmd.finish) begin
            if (disabled) begin
                r_integ <= '0;
            end else if (dt_ok) begin
                r_integ <= v_clamp[fwc_pkg::OutW-1:0];
            end
        end
    end

    assign o_d_current_ua = r_d_out;
    assign o_step_applied = r_applied;

endmodule

// ===== src/field_weakening_current_reference_unit.sv =====
// ----------------------------------------------------------------------------
// field_weakening_current_reference_unit
// Negative d-axis current reference from speed, voltage saturation and step.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one transaction per control step (op, speed, volt_sat,
//            step_time_us). Accepted only while the sequencer is idle.
//   o_out  : one transaction per input (d_current_ua, step_applied).
//   APB    : start_speed at 0x0, max_weakening_ua at 0x4; write only while
//            no transaction is in flight. pready is tied high.
// Sequence:
//   A step that needs the linear ratio passes one multiply, 28
//   restoring-divide iterations (one quotient bit per cycle through a
//   single subtractor) and one finish before o_out goes valid.
//   Clear, disabled, invalid step time or a saturated/zero linear term skip
//   the divider and go from multiply straight to finish. A new input is
//   taken in the cycle after finish at the earliest: one step at a time.
// Stall: the result sits in the output register; the next input is still
//   accepted and computed, then waits in finish until o_out is taken.
// Reset: configuration, integrator and all control state cleared; no
//   output transaction pending.
// ----------------------------------------------------------------------------
module field_weakening_current_reference_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    fwc_in_if.sink                      i_in,
    fwc_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fwc_pkg::AddrW-1:0]   paddr,
    input  logic [fwc_pkg::DataW-1:0]   pwdata,
    output logic [fwc_pkg::DataW-1:0]   prdata,
    output logic                        pready
);

    fwc_pkg::t_cfg    cfg;
    fwc_pkg::t_cmd    cmd;
    fwc_pkg::t_status status;

    // configuration space
    fwc_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer owns the handshakes and the divide counter
    fwc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // arithmetic, integrator state and output payload register
    fwc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_op           (i_in.op),
        .i_speed        (i_in.speed),
        .i_volt_sat     (i_in.volt_sat),
        .i_step_time_us (i_in.step_time_us),
        .o_d_current_ua (o_out.d_current_ua),
        .o_step_applied (o_out.step_applied)
    );

endmodule

// ===== src/fwc_checker.sv =====
// ----------------------------------------------------------------------------
// fwc_checker
// Port-level checks of the field weakening current unit, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fwc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [fwc_pkg::OutW-1:0]    i_d_current_ua,
    input  logic                               i_step_applied
);

    // a pending result is not withdrawn
    `FWC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)

    // one transaction at a time: busy right after an accept
    `FWC_ASSERT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)

    `FWC_ASSERT_MSG(a_not_positive, i_clk, i_rst_n, i_out_valid |-> (i_d_current_ua[fwc_pkg::OutW-1] || (i_d_current_ua == '0)), "positive d current")

    `FWC_ASSERT_MSG(a_zero_when_skipped, i_clk, i_rst_n, i_out_valid && !i_step_applied |-> (i_d_current_ua == '0), "nonzero current on skipped step")

endmodule

bind field_weakening_current_reference_unit fwc_checker u_fwc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_d_current_ua (o_out.d_current_ua),
    .i_step_applied (o_out.step_applied)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the field weakening d-axis current reference unit.
// Steps are driven with random gaps, results taken with random stalls, and each
// result is checked against a cycle-free model of the linear term, integrator
// and clamps. Registers are reprogrammed over APB between idle phases.
// ----------------------------------------------------------------------------
module tb_top;

    // op codes of the input transaction
    localparam logic OP_STEP  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // register byte addresses, index taken from paddr[2]
    localparam logic [fwc_pkg::AddrW-1:0] ADDR_START_SPEED = {fwc_pkg::RegStartSpeed, 2'b00};
    localparam logic [fwc_pkg::AddrW-1:0] ADDR_MAX_WEAK    = {fwc_pkg::RegMaxWeak, 2'b00};

    // integrator slopes in uA per us
    localparam longint FallUaPerUs = 100;
    localparam longint RiseUaPerUs = 10;

    localparam int MaxWeakUa   = 200000000;  // largest legal weakening limit
    localparam int SettleCyc   = 40;         // longer than the divide path
    localparam int CycleLimit  = 600000;
    localparam int RandPhases  = 10;
    localparam int ReportLimit = 10;

    typedef struct {
        logic                         op;
        logic [fwc_pkg::SpeedW-1:0]   speed;
        logic                         sat;
        logic [fwc_pkg::DtW-1:0]      dt;
    } t_step;

    typedef struct {
        logic signed [fwc_pkg::OutW-1:0] d_ua;
        logic                            applied;
    } t_dref;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [fwc_pkg::AddrW-1:0]    paddr;
    logic [fwc_pkg::DataW-1:0]    pwdata;
    logic [fwc_pkg::DataW-1:0]    prdata;
    logic                         pready;

    fwc_in_if  in_ch ();
    fwc_out_if out_ch ();

    field_weakening_current_reference_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_step pending_steps[$];   // steps waiting to be driven
    t_dref expected_refs[$];   // predicted results, oldest first

    // shadow of the programmed registers and the integrator
    logic [fwc_pkg::StartW-1:0] cfg_start = '0;
    logic [fwc_pkg::MaxW-1:0]   cfg_max   = '0;
    longint                     integ_ua  = 0;

    logic in_fire  = 1'b0;     // input transaction at the last rising edge
    logic out_fire = 1'b0;     // output transaction at the last rising edge
    int   in_wait  = 0;        // idle cycles left before next step
    int   out_hold = 0;        // stall cycles left on the result side
    int   quiet_left = 0;      // while nonzero neither side idles
    logic sat_level = 1'b0;    // saturation flag runs in streaks
    int   n_errors = 0;
    int   cycle_cnt = 0;

    initial forever #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor: one step of the current reference
    // Special cases in order: clear, disabled, bad step time. Only a valid
    // step touches the integrator clamp, so a lowered limit lands there.
    // ------------------------------------------------------------------------
    function automatic t_dref predict_dref(t_step s);
        t_dref       r;
        logic [31:0] mag;
        longint      excess;
        longint      lin;
        longint      v;
        longint      lo;
        r.d_ua    = '0;
        r.applied = 1'b0;
        if (s.op == OP_CLEAR || cfg_max == '0) begin
            integ_ua = 0;
            return r;
        end
        if (s.dt == '0 || s.dt > fwc_pkg::StepMaxUs)
            return r;

        // linear term; the most negative speed has magnitude 2^31
        lin = 0;
        if (cfg_start != '0) begin
            mag = s.speed[fwc_pkg::SpeedW-1] ? (32'd0 - s.speed) : s.speed;
            if (longint'(mag) > longint'(cfg_start)) begin
                excess = longint'(mag) - longint'(cfg_start);
                if (excess >= longint'(cfg_start))
                    lin = -longint'(cfg_max);
                else
                    lin = -((longint'(cfg_max) * excess) / longint'(cfg_start));
            end
        end

        // integrator: fall while saturated, recover only while negative
        v  = integ_ua;
        lo = -longint'(cfg_max);
        if (s.sat)
            v = v - FallUaPerUs * longint'(s.dt);
        else if (v < 0)
            v = v + RiseUaPerUs * longint'(s.dt);
        if (v < lo)
            v = lo;
        if (v > 0)
            v = 0;
        integ_ua = v;

        v = (lin < v) ? lin : v;
        r.d_ua    = v[fwc_pkg::OutW-1:0];
        r.applied = 1'b1;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic int draw_idle();
        return (quiet_left > 0) ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic void push_step(logic op, logic [fwc_pkg::SpeedW-1:0] spd,
                                      logic sat, logic [fwc_pkg::DtW-1:0] dt);
        t_step s;
        s.op    = op;
        s.speed = spd;
        s.sat   = sat;
        s.dt    = dt;
        pending_steps.push_back(s);
    endfunction

    // Speeds cluster around the start speed so the ratio path gets exercised;
    // one in five, and all with a zero start speed, span the whole signed range.
    function automatic logic [fwc_pkg::SpeedW-1:0] pick_speed();
        int          sel;
        longint      base;
        longint      m;
        logic [31:0] s;
        sel  = $urandom_range(0, 9);
        base = longint'(cfg_start);
        if (sel < 2 || cfg_start == '0)
            return $urandom();
        if (sel < 7)
            m = base - base / 2 + longint'({$urandom(), $urandom()} % (2 * base + 1));
        else if (sel < 8)
            m = base + longint'($urandom_range(0, 4)) - 2;
        else
            m = longint'({$urandom(), $urandom()} % (base + 1));
        if (m < 0)
            m = 0;
        if (m >= 64'h8000_0000)
            return 32'h8000_0000;
        s = m[31:0];
        return $urandom_range(0, 1) ? (32'd0 - s) : s;
    endfunction

    function automatic logic [fwc_pkg::DtW-1:0] pick_dt();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 4)  return '0;
        if (sel < 8)  return fwc_pkg::DtW'($urandom_range(100001, 131071));
        if (sel < 10) return fwc_pkg::StepMaxUs;
        if (sel < 12) return fwc_pkg::DtW'(1);
        if (sel < 45) return fwc_pkg::DtW'($urandom_range(1, 200));
        if (sel < 75) return fwc_pkg::DtW'($urandom_range(1, 5000));
        return fwc_pkg::DtW'($urandom_range(1, 100000));
    endfunction

    function automatic void push_random_step();
        logic op;
        op = ($urandom_range(0, 31) == 0) ? OP_CLEAR : OP_STEP;
        // streaky saturation drives the integrator to both clamps
        if ($urandom_range(0, 5) == 0)
            sat_level = ~sat_level;
        push_step(op, pick_speed(), sat_level, pick_dt());
    endfunction

    // APB write: setup, then access; the register lands at the access edge
    task automatic apb_write(logic [fwc_pkg::AddrW-1:0] addr,
                             logic [fwc_pkg::DataW-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (addr == ADDR_MAX_WEAK)
            cfg_max = data[fwc_pkg::MaxW-1:0];
        else
            cfg_start = data[fwc_pkg::StartW-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Wait until every step is driven and every result is back, then let the
    // block settle before touching the registers.
    task automatic wait_drained();
        while (pending_steps.size() != 0 || in_ch.valid || expected_refs.size() != 0)
            @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Input driver: holds a step until taken, then idles a drawn gap
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : step_driver
        t_step s;
        if (in_ch.valid && !in_fire) begin
            // still waiting for the transaction to be taken
        end else if (in_wait > 0) begin
            in_ch.valid <= 1'b0;
            in_wait     <= in_wait - 1;
        end else if (i_rst_n && pending_steps.size() != 0) begin
            s = pending_steps.pop_front();
            in_ch.op           <= s.op;
            in_ch.speed        <= s.speed;
            in_ch.volt_sat     <= s.sat;
            in_ch.step_time_us <= s.dt;
            in_ch.valid        <= 1'b1;
            in_wait            <= draw_idle();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // Result side ready: after each taken result, stall a drawn number of
    // cycles so backpressure falls on different points of the computation.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin : ready_driver
        int n;
        n = out_hold;
        if (out_fire)
            n = draw_idle();
        else if (n > 0)
            n = n - 1;
        out_hold     <= n;
        out_ch.ready <= (n == 0);
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on each accepted step, checks each accepted result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_step got;
        t_dref want;
        cycle_cnt = cycle_cnt + 1;
        if (cycle_cnt > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_cnt);
            $display("simulation failed");
            $finish;
        end else begin
            if (quiet_left > 0)
                quiet_left <= quiet_left - 1;
            else if ($urandom_range(0, 299) == 0)
                quiet_left <= $urandom_range(50, 300);

            if (!i_rst_n) begin
                in_fire  <= 1'b0;
                out_fire <= 1'b0;
            end else begin
                in_fire  <= in_ch.valid && in_ch.ready;
                out_fire <= out_ch.valid && out_ch.ready;

                if (in_ch.valid && in_ch.ready) begin
                    got.op    = in_ch.op;
                    got.speed = in_ch.speed;
                    got.sat   = in_ch.volt_sat;
                    got.dt    = in_ch.step_time_us;
                    expected_refs.push_back(predict_dref(got));
                end

                if (out_ch.valid && out_ch.ready) begin
                    if (expected_refs.size() == 0) begin
                        if (n_errors < ReportLimit)
                            $display("unexpected result: d=%0d applied=%0b",
                                     out_ch.d_current_ua, out_ch.step_applied);
                        n_errors = n_errors + 1;
                    end else begin
                        want = expected_refs.pop_front();
                        if (out_ch.d_current_ua !== want.d_ua ||
                            out_ch.step_applied !== want.applied) begin
                            if (n_errors < ReportLimit)
                                $display("mismatch: exp d=%0d a=%0b, got d=%0d a=%0b",
                                         want.d_ua, want.applied,
                                         out_ch.d_current_ua, out_ch.step_applied);
                            n_errors = n_errors + 1;
                        end
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int                         k;
        int                         n;
        logic [fwc_pkg::StartW-1:0] st;
        logic [fwc_pkg::MaxW-1:0]   mx;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.op           = OP_STEP;
        in_ch.speed        = '0;
        in_ch.volt_sat     = 1'b0;
        in_ch.step_time_us = '0;
        out_ch.ready       = 1'b0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // out of reset the limit is zero: block disabled
        push_step(OP_STEP, 32'h0012_3456, 1'b1, fwc_pkg::DtW'(100));
        push_step(OP_CLEAR, 32'h8000_0000, 1'b0, fwc_pkg::StepMaxUs);
        wait_drained();

        // start speed 1.0 in Q16.16, limit 1 A
        apb_write(ADDR_START_SPEED, 32'h0001_0000);
        apb_write(ADDR_MAX_WEAK, fwc_pkg::DataW'(1000000));

        push_step(OP_CLEAR, 32'h7FFF_FFFF, 1'b1, fwc_pkg::StepMaxUs);  // clear request
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::DtW'(1));     // standstill
        push_step(OP_STEP, 32'h0001_0000, 1'b0, fwc_pkg::DtW'(1));     // exactly at start
        push_step(OP_STEP, 32'h0001_0001, 1'b0, fwc_pkg::DtW'(1));     // just above start
        push_step(OP_STEP, 32'hFFFE_8000, 1'b0, fwc_pkg::DtW'(1));     // -1.5, half way
        push_step(OP_STEP, 32'h0001_FFFF, 1'b0, fwc_pkg::DtW'(1));     // just below limit
        push_step(OP_STEP, 32'h0002_0000, 1'b0, fwc_pkg::DtW'(1));     // excess == start
        push_step(OP_STEP, 32'h7FFF_FFFF, 1'b0, fwc_pkg::DtW'(1));     // largest positive
        push_step(OP_STEP, 32'h8000_0000, 1'b0, fwc_pkg::DtW'(1));     // most negative
        push_step(OP_STEP, 32'hFFFF_FFFF, 1'b0, fwc_pkg::DtW'(1));     // tiny negative
        push_step(OP_STEP, 32'h0000_0000, 1'b1, fwc_pkg::StepMaxUs);   // integrator to clamp
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::StepMaxUs);   // full recovery
        push_step(OP_STEP, 32'h0000_0000, 1'b1, fwc_pkg::DtW'(1));
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::DtW'(0));     // bad step time, kept
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::StepMaxUs + 1);
        push_step(OP_STEP, 32'h0000_0000, 1'b0, 17'h1FFFF);
        push_step(OP_STEP, 32'h0001_4000, 1'b0, fwc_pkg::DtW'(5));     // both terms negative
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::StepMaxUs);
        push_step(OP_STEP, 32'h0000_0000, 1'b1, fwc_pkg::DtW'(50000));
        push_step(OP_CLEAR, 32'h0000_0000, 1'b0, fwc_pkg::DtW'(1));
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::DtW'(10));    // no rise above zero
        push_step(OP_STEP, 32'h8001_0000, 1'b1, fwc_pkg::DtW'(20000));
        wait_drained();

        // lowered limit with the integrator at the old clamp
        apb_write(ADDR_MAX_WEAK, fwc_pkg::DataW'(300000));
        push_step(OP_STEP, 32'h0000_0000, 1'b0, fwc_pkg::DtW'(1));
        wait_drained();

        // zero limit clears the integrator
        apb_write(ADDR_MAX_WEAK, '0);
        push_step(OP_STEP, 32'h0000_0000, 1'b1, fwc_pkg::DtW'(1));
        wait_drained();

        // linear term off, widest limit
        apb_write(ADDR_START_SPEED, '0);
        apb_write(ADDR_MAX_WEAK, fwc_pkg::DataW'(MaxWeakUa));
        push_step(OP_STEP, 32'h8000_0000, 1'b1, fwc_pkg::StepMaxUs);
        wait_drained();

        // random phases; registers change between phases, integrator is
        // left as it is so a lowered limit hits it through the clamp
        for (k = 0; k < RandPhases; k++) begin
            case (k)
                0: begin
                    st = 31'h7FFF_FFFF;
                    mx = fwc_pkg::MaxW'(MaxWeakUa);
                end
                1: begin
                    st = fwc_pkg::StartW'(1);
                    mx = fwc_pkg::MaxW'(1);
                end
                2: begin
                    st = '0;
                    mx = fwc_pkg::MaxW'($urandom_range(1, MaxWeakUa));
                end
                3: begin
                    st = fwc_pkg::StartW'($urandom());
                    mx = '0;
                end
                default: begin
                    case ($urandom_range(0, 2))
                        0: st = fwc_pkg::StartW'($urandom_range(1, 32'h0000_FFFF));
                        1: st = fwc_pkg::StartW'($urandom_range(32'h0001_0000,
                                                                32'h1000_0000));
                        default: st = fwc_pkg::StartW'($urandom());
                    endcase
                    if ($urandom_range(0, 1))
                        mx = fwc_pkg::MaxW'($urandom_range(1, 5000));
                    else
                        mx = fwc_pkg::MaxW'($urandom_range(1, MaxWeakUa));
                end
            endcase
            apb_write(ADDR_START_SPEED, fwc_pkg::DataW'(st));
            apb_write(ADDR_MAX_WEAK, fwc_pkg::DataW'(mx));
            n = (mx == '0) ? 30 : 100;
            repeat (n) push_random_step();
            wait_drained();
        end

        if (n_errors == 0 && expected_refs.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/fwc_pkg.sv
src/fwc_if.sv
src/fwc_regs.sv
src/fwc_ctrl.sv
src/fwc_dp.sv
src/field_weakening_current_reference_unit.sv
src/fwc_checker.sv
tb/sv/tb_top.sv
